@@ src/scd_pkg.sv @@
// Shared types and constants for the sidechain ducker.
package scd_pkg;

   localparam int ENV_BITS      = 17;
   localparam int LEVEL_BITS    = 16;
   localparam int AMOUNT_BITS   = 8;
   localparam int COEF_BITS     = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [LEVEL_BITS-1:0] SC_THRESHOLD = 16'd66;
   localparam logic [ENV_BITS-1:0]   ENV_ONE      = 17'h10000;

   localparam logic [AMOUNT_BITS-1:0] AMOUNT_RESET  = 8'd192;
   localparam logic                   INVERT_RESET  = 1'b0;
   localparam logic [COEF_BITS-1:0]   RELEASE_RESET = 16'd65525;

   localparam logic [CSR_IDX_BITS-1:0] CSR_AMOUNT  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELEASE = 2'd2;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic accept;
      logic env_step;
      logic gain_step;
      logic mul_left;
      logic mul_right;
      logic load_out;
   } scd_cmd_type;

   typedef struct packed {
      logic out_free;
   } scd_status_type;

endpackage

@@ src/scd_ctrl.sv @@
// Sequencer that steps one frame through envelope, gain and sample scaling.
module scd_ctrl
   import scd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_op,
   output logic           req_tready,
   input  scd_status_type status,
   output scd_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENV,
      ST_GAIN,
      ST_MUL_L,
      ST_MUL_R,
      ST_SEND
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_op == OP_FRAME) begin
                  state_ff <= ST_ENV;
               end
            end
            ST_ENV:   state_ff <= ST_GAIN;
            ST_GAIN:  state_ff <= ST_MUL_L;
            ST_MUL_L: state_ff <= ST_MUL_R;
            ST_MUL_R: state_ff <= ST_SEND;
            ST_SEND: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_tvalid;
      cmd.env_step  = (state_ff == ST_ENV);
      cmd.gain_step = (state_ff == ST_GAIN);
      cmd.mul_left  = (state_ff == ST_MUL_L);
      cmd.mul_right = (state_ff == ST_MUL_R);
      cmd.load_out  = (state_ff == ST_SEND) && status.out_free;
   end

endmodule

@@ src/scd_datapath.sv @@
// Envelope, gain and sample scaling datapath with config registers and output register.
module scd_datapath
   import scd_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  scd_cmd_type                   cmd,
   output scd_status_type                status,
   input  logic                          csr_we,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                          req_op,
   input  logic signed [SAMPLE_BITS-1:0] req_left,
   input  logic signed [SAMPLE_BITS-1:0] req_right,
   input  logic [LEVEL_BITS-1:0]         req_level,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic signed [SAMPLE_BITS-1:0] rsp_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_right
);

   localparam int GAIN_BITS = GAIN_FRAC_BITS + 1;
   localparam int WIDE_BITS = ENV_BITS + 8;
   localparam int GAIN_SHL  = (GAIN_FRAC_BITS >= 16) ? GAIN_FRAC_BITS - 16 : 0;
   localparam int GAIN_SHR  = (GAIN_FRAC_BITS >= 16) ? 0 : 16 - GAIN_FRAC_BITS;
   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;

   // configuration
   logic [AMOUNT_BITS-1:0] amount_ff;
   logic                   invert_ff;
   logic [COEF_BITS-1:0]   coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amount_ff <= AMOUNT_RESET;
         invert_ff <= INVERT_RESET;
         coef_ff   <= RELEASE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AMOUNT:  amount_ff <= csr_wdata[AMOUNT_BITS-1:0];
            CSR_INVERT:  invert_ff <= csr_wdata[0];
            CSR_RELEASE: coef_ff   <= csr_wdata[COEF_BITS-1:0];
            default:     ;
         endcase
      end
   end

   // input beat holding
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;
   logic [LEVEL_BITS-1:0]         level_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         left_ff  <= req_left;
         right_ff <= req_right;
         level_ff <= req_level;
      end
   end

   // envelope
   logic [ENV_BITS-1:0]           env_ff, env_in;
   logic [ENV_BITS+COEF_BITS-1:0] decay_prod;

   assign decay_prod = env_ff * coef_ff;

   always_comb begin
      env_in = env_ff;
      if (cmd.accept && req_op == OP_CLEAR) begin
         env_in = '0;
      end else if (cmd.env_step) begin
         if (level_ff >= SC_THRESHOLD) begin
            env_in = ENV_ONE;
         end else begin
            env_in = decay_prod[ENV_BITS+COEF_BITS-1:COEF_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
      end else begin
         env_ff <= env_in;
      end
   end

   // gain: amount*257 is the byte repeated twice
   logic [15:0]                 amount_x257;
   logic [ENV_BITS-1:0]         env_sel;
   logic [ENV_BITS+15:0]        duck_prod;
   logic [ENV_BITS-1:0]         gain_q16;
   logic [WIDE_BITS-1:0]        gain_wide;
   logic [GAIN_BITS-1:0]        gain_ff, gain_in;

   assign amount_x257 = {amount_ff, amount_ff};
   assign env_sel     = invert_ff ? (ENV_ONE - env_ff) : env_ff;
   assign duck_prod   = amount_x257 * env_sel;
   assign gain_q16    = ENV_ONE - {1'b0, duck_prod[31:16]};
   assign gain_wide   = (WIDE_BITS'(gain_q16) << GAIN_SHL) >> GAIN_SHR;
   assign gain_in     = cmd.gain_step ? gain_wide[GAIN_BITS-1:0] : gain_ff;

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
   end

   // shared sample multiplier, left then right; taking the upper product bits gives floor division
   logic signed [SAMPLE_BITS-1:0] mul_x;
   logic signed [PROD_BITS-1:0]   mul_prod;
   logic signed [SAMPLE_BITS-1:0] mul_res;
   logic signed [SAMPLE_BITS-1:0] left_res_ff, right_res_ff;

   assign mul_x    = cmd.mul_right ? right_ff : left_ff;
   assign mul_prod = mul_x * $signed({1'b0, gain_ff});
   assign mul_res  = mul_prod[GAIN_FRAC_BITS+SAMPLE_BITS-1:GAIN_FRAC_BITS];

   always_ff @(posedge clock) begin
      if (cmd.mul_left) begin
         left_res_ff <= mul_res;
      end
      if (cmd.mul_right) begin
         right_res_ff <= mul_res;
      end
   end

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_out) begin
         rsp_left_ff  <= left_res_ff;
         rsp_right_ff <= right_res_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_left        = rsp_left_ff;
   assign rsp_right       = rsp_right_ff;

`ifndef SYNTHESIS
   a_env_range: assert property (@(posedge clock) disable iff (reset)
      env_ff <= ENV_ONE)
      else $error("envelope above unity");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten while holding a beat");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.env_step, cmd.gain_step, cmd.mul_left,
                cmd.mul_right, cmd.load_out}))
      else $error("more than one datapath step at once");

   a_clear_env: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_op == OP_CLEAR) |=> env_ff == '0)
      else $error("clear did not zero envelope");
`endif

endmodule

@@ src/sidechain_ducker.sv @@
// Top level of the stereo sidechain ducker.
// A frame beat goes from acceptance to the result entering the output register in steps:
// accept, the envelope multiply, the gain multiply, then left and then right on the
// single sample multiplier that scales both, and last the load of the result.
// The next beat is taken as soon as the result sits in the output register, even while it
// waits to be taken; if the previous result is still held there, the load waits for it.
// A clear beat (tuser high) gives no result.
module sidechain_ducker
   import scd_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         csr_we,
   input  logic [CSR_IDX_BITS-1:0]                      csr_index,
   input  logic [CSR_DATA_BITS-1:0]                     csr_wdata,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // left_in, right_in, sidechain_level, zero pad
   input  logic [((2*SAMPLE_BITS+LEVEL_BITS+7)/8)*8-1:0] req_tdata,
   // op
   input  logic                                         req_tuser,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // left_out, right_out, zero pad
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]           rsp_tdata
);

   localparam int RSP_DATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;

   scd_cmd_type                   cmd;
   scd_status_type                status;
   logic signed [SAMPLE_BITS-1:0] rsp_left, rsp_right;

   scd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scd_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_op     (req_tuser),
      .req_left   (req_tdata[SAMPLE_BITS-1:0]),
      .req_right  (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .req_level  (req_tdata[2*SAMPLE_BITS+LEVEL_BITS-1:2*SAMPLE_BITS]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_left   (rsp_left),
      .rsp_right  (rsp_right)
   );

   assign rsp_tdata = RSP_DATA_BITS'({rsp_right, rsp_left});

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the stereo sidechain ducker.
module tb
   import scd_pkg::*;
();

   localparam int SAMPLE_W      = 24;
   localparam int REQ_W         = ((2*SAMPLE_W+LEVEL_BITS+7)/8)*8;
   localparam int RSP_W         = ((2*SAMPLE_W+7)/8)*8;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 50;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_BEAT, ROW_REG} row_kind_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] right;
      logic [SAMPLE_W-1:0] left;
   } frame_type;

   typedef struct {
      row_kind_type             kind;
      logic                     op;
      logic [SAMPLE_W-1:0]      left;
      logic [SAMPLE_W-1:0]      right;
      logic [LEVEL_BITS-1:0]    level;
      logic [CSR_IDX_BITS-1:0]  index;
      logic [CSR_DATA_BITS-1:0] value;
      bit                       typed;
      frame_type                want;
   } row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_W-1:0]         req_tdata = '0;  // left_in, right_in, sidechain_level
   logic                     req_tuser = 1'b0; // op
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_W-1:0]         rsp_tdata;       // left_out, right_out

   // predictor state
   logic [AMOUNT_BITS-1:0] amount_m = AMOUNT_RESET;
   logic                   invert_m = INVERT_RESET;
   logic [COEF_BITS-1:0]   coef_m   = RELEASE_RESET;
   logic [ENV_BITS-1:0]    env_m    = '0;

   frame_type pending_frames[$];
   row_type   directed_rows[$];
   int     fail_count   = 0;
   int     cycle_count  = 0;
   int     tx_gap_pct   = 0;
   int     rx_stall_pct = 0;
   int     hold_count   = 0;
   bit     hold_request = 1'b0;
   int     tx_modes[4]  = '{0, 80, 0, 20};
   int     rx_modes[4]  = '{0, 0, 80, 20};

   sidechain_ducker DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // floor(sample * gain / 2^16), truncated back to the sample width
   function automatic logic [SAMPLE_W-1:0] scaled(input logic [SAMPLE_W-1:0] s,
                                                  input logic [ENV_BITS-1:0] gain);
      longint p;
      p = longint'($signed(s)) * longint'(gain);
      return SAMPLE_W'(p >>> 16);
   endfunction

   function automatic frame_type duck_frame(input logic [SAMPLE_W-1:0] l, r,
                                            input logic [LEVEL_BITS-1:0] lvl);
      longint unsigned e;
      longint unsigned depth;
      logic [ENV_BITS-1:0] gain;
      frame_type f;
      if (lvl >= SC_THRESHOLD)
         env_m = ENV_ONE;
      else
         env_m = ENV_BITS'((longint'(env_m) * longint'(coef_m)) >> 16);
      e = invert_m ? longint'(ENV_ONE - env_m) : longint'(env_m);
      depth = (longint'(amount_m) * 257 * e) >> 16;
      gain = ENV_BITS'(65536 - depth);
      f.left  = scaled(l, gain);
      f.right = scaled(r, gain);
      return f;
   endfunction

   function automatic void beat_row(input logic op, input logic [SAMPLE_W-1:0] l, r,
                                    input logic [LEVEL_BITS-1:0] lvl, input bit typed,
                                    input logic [SAMPLE_W-1:0] want_l, want_r);
      row_type row;
      row.kind = ROW_BEAT;
      row.op = op;
      row.left = l;
      row.right = r;
      row.level = lvl;
      row.index = '0;
      row.value = '0;
      row.typed = typed;
      row.want.left = want_l;
      row.want.right = want_r;
      directed_rows.push_back(row);
   endfunction

   function automatic void reg_row(input logic [CSR_IDX_BITS-1:0] idx,
                                   input logic [CSR_DATA_BITS-1:0] val);
      row_type row;
      row.kind = ROW_REG;
      row.op = OP_FRAME;
      row.left = '0;
      row.right = '0;
      row.level = '0;
      row.index = idx;
      row.value = val;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic write_register(input logic [CSR_IDX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_AMOUNT:  amount_m = val[AMOUNT_BITS-1:0];
         CSR_INVERT:  invert_m = val[0];
         CSR_RELEASE: coef_m = val[COEF_BITS-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, wait for every pending frame, then let the pipeline drain
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_beat(input logic op, input logic [SAMPLE_W-1:0] l, r,
                            input logic [LEVEL_BITS-1:0] lvl, input bit typed,
                            input frame_type want);
      int gap;
      frame_type f;
      gap = 0;
      while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {lvl, r, l};
      do @(posedge clock); while (!req_tready);
      if (op == OP_CLEAR) begin
         env_m = '0;
      end else begin
         f = duck_frame(l, r, lvl);
         pending_frames.push_back(typed ? want : f);
      end
   endtask

   task automatic random_beat();
      logic op;
      logic [LEVEL_BITS-1:0] lvl;
      op = ($urandom_range(15) == 0) ? OP_CLEAR : OP_FRAME;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: lvl = LEVEL_BITS'($urandom_range(65));
         5: lvl = LEVEL_BITS'($urandom_range(72, 60));
         6, 7: lvl = LEVEL_BITS'($urandom_range(65535, 66));
         default: lvl = LEVEL_BITS'($urandom);
      endcase
      send_beat(op, pick_sample(), pick_sample(), lvl, 1'b0, '0);
   endtask

   task automatic check_frame(input logic [SAMPLE_W-1:0] l, r);
      frame_type want;
      if (pending_frames.size() == 0) begin
         $error("result with no frame pending: left_out %h right_out %h", l, r);
         fail_count++;
      end else begin
         want = pending_frames.pop_front();
         if (l !== want.left) begin
            $error("left_out: expected %h, got %h", want.left, l);
            fail_count++;
         end
         if (r !== want.right) begin
            $error("right_out: expected %h, got %h", want.right, r);
            fail_count++;
         end
      end
   endtask

   // result side: check beats, then choose next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_frame(rsp_tdata[SAMPLE_W-1:0], rsp_tdata[2*SAMPLE_W-1:SAMPLE_W]);
      if (hold_request) begin
         hold_request = 1'b0;
         hold_count = RX_HOLD_CYCLES;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   initial begin
      // reset values: no duck while the envelope is zero, so out equals in
      beat_row(OP_FRAME, 24'h000000, 24'h000000, 16'd0, 1, 24'h000000, 24'h000000);
      beat_row(OP_FRAME, 24'h800000, 24'h7FFFFF, 16'd65, 1, 24'h800000, 24'h7FFFFF);
      beat_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 16'd66, 0, '0, '0);
      beat_row(OP_FRAME, 24'hFFFFFF, 24'h000001, 16'hFFFF, 0, '0, '0);
      beat_row(OP_FRAME, 24'h01E240, 24'hF60453, 16'd0, 0, '0, '0);
      beat_row(OP_CLEAR, 24'hABCDEF, 24'h123456, 16'hFFFF, 0, '0, '0);
      beat_row(OP_FRAME, 24'h800000, 24'h7FFFFF, 16'd0, 1, 24'h800000, 24'h7FFFFF);
      // full duck, upper write bits must be dropped
      reg_row(CSR_AMOUNT, 16'hFFFF);
      beat_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 16'hFFFF, 0, '0, '0);
      // zero release: envelope gone on the first quiet frame
      reg_row(CSR_RELEASE, 16'h0000);
      beat_row(OP_FRAME, 24'h001234, 24'hFFEDCC, 16'd0, 1, 24'h001234, 24'hFFEDCC);
      reg_row(CSR_INVERT, 16'h0003);
      beat_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 16'd0, 0, '0, '0);
      beat_row(OP_FRAME, 24'h345678, 24'hCBA988, 16'hFFFF, 1, 24'h345678, 24'hCBA988);
      reg_row(CSR_UNUSED, 16'hABCD);
      reg_row(CSR_AMOUNT, 16'h1200);
      beat_row(OP_FRAME, 24'h7FFFFF, 24'h800000, 16'd0, 1, 24'h7FFFFF, 24'h800000);
      reg_row(CSR_INVERT, 16'hFFFE);
      reg_row(CSR_AMOUNT, 16'h3380);
      reg_row(CSR_RELEASE, 16'hFFFF);
      beat_row(OP_FRAME, 24'h400000, 24'hC00000, 16'd100, 0, '0, '0);
      beat_row(OP_FRAME, 24'h400000, 24'hC00000, 16'd0, 0, '0, '0);
      beat_row(OP_FRAME, 24'h3FFFFF, 24'hC00001, 16'd65, 0, '0, '0);
      beat_row(OP_CLEAR, 24'h555555, 24'hAAAAAA, 16'd0, 0, '0, '0);
      beat_row(OP_FRAME, 24'h2AAAAA, 24'hD55556, 16'd0, 0, '0, '0);
      beat_row(OP_FRAME, 24'h000001, 24'hFFFFFF, 16'd66, 0, '0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            wait_quiet();
            write_register(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_beat(directed_rows[i].op, directed_rows[i].left, directed_rows[i].right,
                      directed_rows[i].level, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_quiet();
         tx_gap_pct = tx_modes[p % 4];
         rx_stall_pct = rx_modes[p % 4];
         case (p)
            0: write_register(CSR_AMOUNT, {8'($urandom), 8'hFF});
            1: write_register(CSR_AMOUNT, {8'($urandom), 8'h00});
            default: write_register(CSR_AMOUNT, 16'($urandom));
         endcase
         write_register(CSR_INVERT, {15'($urandom), p[0]});
         case (p)
            2: write_register(CSR_RELEASE, 16'h0000);
            3, 6: write_register(CSR_RELEASE, 16'hFFFF);
            5: write_register(CSR_RELEASE, 16'($urandom));
            default: write_register(CSR_RELEASE, 16'($urandom_range(65535, 60000)));
         endcase
         write_register(CSR_UNUSED, 16'($urandom));
         // stall the result side long enough to back up the input
         if (p == 3) hold_request = 1'b1;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (p == 1 && n == PHASE_BEATS/2) wait_quiet();
            random_beat();
         end
      end

      wait_quiet();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
